### rtl/rewc_pkg.sv
// Package for the rotational event warp contrast core.
// Holds widths, reset values, register codes, state and status types.
// No dependencies; every rtl file refers to it by scoped names.
`default_nettype none

package rewc_pkg;

  localparam int IMG_WIDTH_DEF  = 1280;
  localparam int IMG_HEIGHT_DEF = 720;
  localparam int COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam int COORD_W  = 11;
  localparam int ANGLE_W  = 16;
  localparam int SUM_W    = 63;
  localparam int TOTAL_W  = 32;
  localparam int Q_FRAC   = 14;
  localparam int Q_ONE    = 1 << Q_FRAC;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 4;

  localparam logic [ANGLE_W-1:0] COS_RESET = 16'h4000;
  localparam logic [ANGLE_W-1:0] SIN_RESET = 16'h0000;
  localparam logic [COORD_W-1:0] CX_RESET  = 11'd600;
  localparam logic [COORD_W-1:0] CY_RESET  = 11'd411;

  typedef enum logic [1:0] {
    REG_COS = 2'd0,
    REG_SIN = 2'd1,
    REG_CX  = 2'd2,
    REG_CY  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] cos_angle;
    logic [ANGLE_W-1:0] sin_angle;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
  } rot_cfg_t;

  typedef struct packed {
    logic finish;
    logic hit;
  } item_cls_t;

  typedef struct packed {
    logic clearing;
  } bk_stat_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } bk_state_t;

endpackage

`default_nettype wire

### rtl/rewc_front.sv
// Front end: rotates each event about the centre and classifies it.
// Four-stage pipeline ending in the pixel index; depends on rewc_pkg.
`default_nettype none

module rewc_front #(
  parameter int IMG_WIDTH  = rewc_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = rewc_pkg::IMG_HEIGHT_DEF,
  parameter int AW         = $clog2(IMG_WIDTH * IMG_HEIGHT)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         take,
  input  wire logic                         in_action,
  input  wire logic [rewc_pkg::COORD_W-1:0] in_event_x,
  input  wire logic [rewc_pkg::COORD_W-1:0] in_event_y,
  input  wire rewc_pkg::rot_cfg_t           cfg,
  input  wire logic                         q_full,
  output logic                              adv,
  output logic                              q_push,
  output logic [$bits(rewc_pkg::item_cls_t)+AW-1:0] q_data
);

  localparam int XW = $clog2(IMG_WIDTH);
  localparam int YW = $clog2(IMG_HEIGHT);
  localparam int DW = rewc_pkg::COORD_W + 1;
  localparam int PW = DW + rewc_pkg::ANGLE_W;
  localparam int SW = PW + 2;
  localparam int QF = rewc_pkg::Q_FRAC;
  localparam logic signed [SW-1:0] X_LIM   = SW'(IMG_WIDTH * rewc_pkg::Q_ONE);
  localparam logic signed [SW-1:0] Y_LIM   = SW'(IMG_HEIGHT * rewc_pkg::Q_ONE);
  localparam logic signed [SW-1:0] NEG_LIM = SW'(-rewc_pkg::Q_ONE);

  logic signed [rewc_pkg::ANGLE_W-1:0] cfg_cos;
  logic signed [rewc_pkg::ANGLE_W-1:0] cfg_sin;
  logic signed [SW-1:0] cxq;
  logic signed [SW-1:0] cyq;

  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                 s1_fin_r, s2_fin_r, s3_fin_r, s4_fin_r;
  logic signed [DW-1:0] s1_dx_r, s1_dy_r;
  logic signed [DW-1:0] s1_dx_nxt, s1_dy_nxt;
  logic signed [PW-1:0] s2_pxc_r, s2_pys_r, s2_pxs_r, s2_pyc_r;
  logic signed [PW-1:0] s2_pxc_nxt, s2_pys_nxt, s2_pxs_nxt, s2_pyc_nxt;
  logic signed [SW-1:0] sx, sy;
  logic [XW-1:0]        s3_wx_r, s3_wx_nxt;
  logic [YW-1:0]        s3_wy_r, s3_wy_nxt;
  logic                 s3_in_r, s3_in_nxt, s4_in_r;
  logic [AW-1:0]        s4_idx_r, s4_idx_nxt;
  rewc_pkg::item_cls_t  cls;

  always_comb begin
    cfg_cos    = $signed(cfg.cos_angle);
    cfg_sin    = $signed(cfg.sin_angle);
    cxq        = $signed(SW'({cfg.center_x, {QF{1'b0}}}));
    cyq        = $signed(SW'({cfg.center_y, {QF{1'b0}}}));
    s1_dx_nxt  = $signed({1'b0, in_event_x}) - $signed({1'b0, cfg.center_x});
    s1_dy_nxt  = $signed({1'b0, in_event_y}) - $signed({1'b0, cfg.center_y});
    s2_pxc_nxt = PW'(s1_dx_r) * PW'(cfg_cos);
    s2_pys_nxt = PW'(s1_dy_r) * PW'(cfg_sin);
    s2_pxs_nxt = PW'(s1_dx_r) * PW'(cfg_sin);
    s2_pyc_nxt = PW'(s1_dy_r) * PW'(cfg_cos);
    sx         = SW'(s2_pxc_r) - SW'(s2_pys_r) + cxq;
    sy         = SW'(s2_pxs_r) + SW'(s2_pyc_r) + cyq;
    s3_in_nxt  = (sx > NEG_LIM) && (sx < X_LIM) && (sy > NEG_LIM) && (sy < Y_LIM);
    s3_wx_nxt  = sx[SW-1] ? '0 : sx[XW+QF-1:QF];
    s3_wy_nxt  = sy[SW-1] ? '0 : sy[YW+QF-1:QF];
    s4_idx_nxt = AW'(s3_wy_r) * AW'(IMG_WIDTH) + AW'(s3_wx_r);
    adv        = !s4_v_r || !q_full;
    q_push     = s4_v_r && !q_full;
    cls.finish = s4_fin_r;
    cls.hit    = s4_in_r;
    q_data     = {cls, s4_idx_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fin_r <= in_action;
      s1_dx_r  <= s1_dx_nxt;
      s1_dy_r  <= s1_dy_nxt;
      s2_fin_r <= s1_fin_r;
      s2_pxc_r <= s2_pxc_nxt;
      s2_pys_r <= s2_pys_nxt;
      s2_pxs_r <= s2_pxs_nxt;
      s2_pyc_r <= s2_pyc_nxt;
      s3_fin_r <= s2_fin_r;
      s3_in_r  <= s3_in_nxt;
      s3_wx_r  <= s3_wx_nxt;
      s3_wy_r  <= s3_wy_nxt;
      s4_fin_r <= s3_fin_r;
      s4_in_r  <= s3_in_r;
      s4_idx_r <= s4_idx_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/rewc_queue.sv
// Short first-in first-out queue between the front and back ends.
// Register storage with read and write pointers; depends on rewc_pkg.
`default_nettype none

module rewc_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = rewc_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      rd_data,
  output logic                   empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] store_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  always_comb begin
    full    = cnt_r == (PTR_W+1)'(DEPTH);
    empty   = cnt_r == '0;
    do_push = push && !full;
    do_pop  = pop && !empty;
    rd_data = store_r[rd_ptr_r];
    cnt_nxt = cnt_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

### rtl/rewc_back.sv
// Back end: pixel store read-modify-write, running totals and result register.
// Holds the per-pixel count and epoch memory; depends on rewc_pkg.
`default_nettype none

module rewc_back #(
  parameter int IMG_WIDTH  = rewc_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = rewc_pkg::IMG_HEIGHT_DEF,
  parameter int COUNT_BITS = rewc_pkg::COUNT_BITS_DEF,
  parameter int AW         = $clog2(IMG_WIDTH * IMG_HEIGHT)
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    q_empty,
  input  wire logic [$bits(rewc_pkg::item_cls_t)+AW-1:0] q_data,
  output logic                                         q_pop,
  output rewc_pkg::bk_stat_t                           stat,
  input  wire logic                                    out_pop,
  output logic                                         out_valid,
  output logic [rewc_pkg::SUM_W-1:0]                   out_sum,
  output logic [rewc_pkg::TOTAL_W-1:0]                 out_in,
  output logic [rewc_pkg::TOTAL_W-1:0]                 out_drop
);

  localparam int PIXELS = IMG_WIDTH * IMG_HEIGHT;
  localparam int MW     = COUNT_BITS + 1;
  localparam int SW     = rewc_pkg::SUM_W;
  localparam int TW     = rewc_pkg::TOTAL_W;
  localparam logic [AW-1:0]         LAST_ADDR = AW'(PIXELS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

  logic [MW-1:0] pix_mem [PIXELS];

  rewc_pkg::bk_state_t state_r, state_nxt;
  rewc_pkg::item_cls_t head_cls;
  logic [AW-1:0]       head_idx;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]       idx_r;
  logic [MW-1:0]       rd_q_r;
  logic                rd_en, mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [MW-1:0]       mem_wdata;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic [TW-1:0]       in_tot_r, in_tot_nxt, out_tot_r, out_tot_nxt;
  logic                epoch_r, epoch_nxt;
  logic                out_v_r, out_v_nxt, out_load;
  logic [SW-1:0]       out_sum_r;
  logic [TW-1:0]       out_in_r, out_drop_r;
  logic                slot_free;
  logic [COUNT_BITS-1:0] cnt, cnt_new;
  logic [COUNT_BITS:0] inc;
  logic [SW:0]         sum_wide;

  always_comb begin
    {head_cls, head_idx} = q_data;
    slot_free    = !out_v_r || out_pop;
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    sum_nxt      = sum_r;
    in_tot_nxt   = in_tot_r;
    out_tot_nxt  = out_tot_r;
    epoch_nxt    = epoch_r;
    out_load     = 1'b0;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx_r;
    cnt          = (rd_q_r[MW-1] == epoch_r) ? rd_q_r[COUNT_BITS-1:0] : '0;
    cnt_new      = cnt;
    inc          = {cnt, 1'b1};
    sum_wide     = {1'b0, sum_r} + (SW+1)'(inc);
    mem_wdata    = {epoch_r, cnt_new};
    case (state_r)
      rewc_pkg::BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) state_nxt = rewc_pkg::BK_IDLE;
      end
      rewc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (head_cls.finish) begin
            if (slot_free) begin
              q_pop       = 1'b1;
              out_load    = 1'b1;
              sum_nxt     = '0;
              in_tot_nxt  = '0;
              out_tot_nxt = '0;
              epoch_nxt   = !epoch_r;
            end
          end else if (head_cls.hit) begin
            q_pop = 1'b1;
            rd_en = 1'b1;
            if (in_tot_r != '1) in_tot_nxt = in_tot_r + 1'b1;
            state_nxt = rewc_pkg::BK_UPDATE;
          end else begin
            q_pop = 1'b1;
            if (out_tot_r != '1) out_tot_nxt = out_tot_r + 1'b1;
          end
        end
      end
      rewc_pkg::BK_UPDATE: begin
        mem_we = 1'b1;
        if (cnt != CNT_MAX) begin
          cnt_new = cnt + 1'b1;
          sum_nxt = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
        end
        mem_wdata = {epoch_r, cnt_new};
        state_nxt = rewc_pkg::BK_IDLE;
      end
      default: state_nxt = rewc_pkg::BK_IDLE;
    endcase
    out_v_nxt = out_load || (out_v_r && !out_pop);
    stat.clearing = state_r == rewc_pkg::BK_CLEAR;
    out_valid = out_v_r;
    out_sum   = out_sum_r;
    out_in    = out_in_r;
    out_drop  = out_drop_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rewc_pkg::BK_CLEAR;
      clr_addr_r <= '0;
      sum_r      <= '0;
      in_tot_r   <= '0;
      out_tot_r  <= '0;
      epoch_r    <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      sum_r      <= sum_nxt;
      in_tot_r   <= in_tot_nxt;
      out_tot_r  <= out_tot_nxt;
      epoch_r    <= epoch_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) idx_r <= head_idx;
    if (out_load) begin
      out_sum_r  <= sum_r;
      out_in_r   <= in_tot_r;
      out_drop_r <= out_tot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) pix_mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_q_r <= pix_mem[head_idx];
  end

endmodule

`default_nettype wire

### rtl/rotational_event_warp_contrast_core.sv
// Top level of the rotational event warp contrast core.
// Configuration registers and the front, queue and back ends; depends on rewc_pkg.
//
// Events enter through a push/full queue interface and pass a four-stage rotation
// and classification pipeline, then a four-entry queue, to the back end. An event
// inside the image is read from the pixel store in the idle state and written back
// in the update state; a dropped event or a finish item is retired in idle, a finish
// item also waiting for the result register to be free. The single-port pixel store
// read-modify-write sets the sustained rate: no new item is taken during a write-back.
// After reset the store is cleared one entry per cycle, all IMG_WIDTH*IMG_HEIGHT
// entries (921600 at the defaults), with full held high; configuration writes are
// taken throughout. Write configuration only while no item is in flight.
`default_nettype none

module rotational_event_warp_contrast_core #(
  parameter int IMG_WIDTH  = rewc_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = rewc_pkg::IMG_HEIGHT_DEF,
  parameter int COUNT_BITS = rewc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          in_action,
  input  wire logic [rewc_pkg::COORD_W-1:0]  in_event_x,
  input  wire logic [rewc_pkg::COORD_W-1:0]  in_event_y,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [rewc_pkg::SUM_W-1:0]         out_sum_of_squares,
  output logic [rewc_pkg::TOTAL_W-1:0]       out_events_in_image,
  output logic [rewc_pkg::TOTAL_W-1:0]       out_events_dropped,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rewc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [rewc_pkg::DATA_W-1:0]   pwdata,
  output logic [rewc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int AW  = $clog2(IMG_WIDTH * IMG_HEIGHT);
  localparam int QDW = $bits(rewc_pkg::item_cls_t) + AW;

  logic [rewc_pkg::ANGLE_W-1:0] cos_r, sin_r;
  logic [rewc_pkg::COORD_W-1:0] cx_r, cy_r;
  rewc_pkg::cfg_reg_t           reg_sel;
  rewc_pkg::rot_cfg_t           cfg;
  rewc_pkg::bk_stat_t           stat;
  logic                         cfg_wr, take, adv;
  logic                         q_push, q_full, q_pop, q_empty;
  logic [QDW-1:0]               q_wdata, q_rdata;
  logic                         out_valid;

  always_comb begin
    reg_sel       = rewc_pkg::cfg_reg_t'(paddr[3:2]);
    cfg_wr        = psel && penable && pwrite;
    pready        = 1'b1;
    cfg.cos_angle = cos_r;
    cfg.sin_angle = sin_r;
    cfg.center_x  = cx_r;
    cfg.center_y  = cy_r;
    full          = stat.clearing || !adv;
    take          = push && !full;
    empty         = !out_valid;
    case (reg_sel)
      rewc_pkg::REG_COS: prdata = rewc_pkg::DATA_W'(cos_r);
      rewc_pkg::REG_SIN: prdata = rewc_pkg::DATA_W'(sin_r);
      rewc_pkg::REG_CX:  prdata = rewc_pkg::DATA_W'(cx_r);
      rewc_pkg::REG_CY:  prdata = rewc_pkg::DATA_W'(cy_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= rewc_pkg::COS_RESET;
      sin_r <= rewc_pkg::SIN_RESET;
      cx_r  <= rewc_pkg::CX_RESET;
      cy_r  <= rewc_pkg::CY_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        rewc_pkg::REG_COS: cos_r <= pwdata[rewc_pkg::ANGLE_W-1:0];
        rewc_pkg::REG_SIN: sin_r <= pwdata[rewc_pkg::ANGLE_W-1:0];
        rewc_pkg::REG_CX:  cx_r  <= pwdata[rewc_pkg::COORD_W-1:0];
        rewc_pkg::REG_CY:  cy_r  <= pwdata[rewc_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  rewc_front #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_action  (in_action),
    .in_event_x (in_event_x),
    .in_event_y (in_event_y),
    .cfg        (cfg),
    .q_full     (q_full),
    .adv        (adv),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  rewc_queue #(
    .DATA_W  (QDW),
    .DEPTH   (rewc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  rewc_back #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .stat       (stat),
    .out_pop    (pop),
    .out_valid  (out_valid),
    .out_sum    (out_sum_of_squares),
    .out_in     (out_events_in_image),
    .out_drop   (out_events_dropped)
  );

endmodule

`default_nettype wire

### rtl/rewc_checker.sv
// Port-level checks for the rotational event warp contrast core.
// Bound to the top level below; depends on rewc_pkg.
`default_nettype none

module rewc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         full,
  input wire logic                         empty,
  input wire logic                         pop,
  input wire logic [rewc_pkg::SUM_W-1:0]   out_sum_of_squares,
  input wire logic [rewc_pkg::TOTAL_W-1:0] out_events_in_image,
  input wire logic [rewc_pkg::TOTAL_W-1:0] out_events_dropped,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [rewc_pkg::PADDR_W-1:0] paddr,
  input wire logic [rewc_pkg::DATA_W-1:0]  pwdata,
  input wire logic [rewc_pkg::DATA_W-1:0]  prdata
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> empty && full)
    else $error("no result and no request accepted after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_sum_of_squares)
      && $stable(out_events_in_image) && $stable(out_events_dropped))
    else $error("waiting result changed or vanished");

  a_angle_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && !paddr[3] ##1 paddr == $past(paddr)
      |-> prdata[rewc_pkg::ANGLE_W-1:0] == $past(pwdata[rewc_pkg::ANGLE_W-1:0]))
    else $error("angle register readback mismatch");

endmodule

bind rotational_event_warp_contrast_core rewc_checker u_rewc_checker (.*);

`default_nettype wire

### dv/rotational_event_warp_contrast_core_tb.sv
`timescale 1ns / 100ps
// Testbench for rotational_event_warp_contrast_core: event and frame-finish requests in,
// frame reports out, checked field by field against an in-bench rotation and pixel model.
// Depends on rewc_pkg and the core RTL; drives the APB-style register port directly.
module rotational_event_warp_contrast_core_tb;
  import rewc_pkg::*;

  localparam int IMG_W = IMG_WIDTH_DEF;
  localparam int IMG_H = IMG_HEIGHT_DEF;
  localparam longint unsigned PIX_MAX = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam longint unsigned SQ_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned TOT_MAX = 64'hFFFF_FFFF;
  localparam bit ACT_EVENT  = 1'b0;
  localparam bit ACT_FINISH = 1'b1;
  localparam int DRAIN_CYCLES = 32;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_ITEMS = 1430;
  localparam int CALM_TAIL = 220;

  typedef struct {
    bit                 action;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } warp_req_t;

  typedef struct {
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] in_image;
    logic [TOTAL_W-1:0] dropped;
  } frame_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 in_action = 1'b0;
  logic [COORD_W-1:0]   in_event_x = '0;
  logic [COORD_W-1:0]   in_event_y = '0;
  logic                 pop = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  wire                  full;
  wire                  empty;
  wire  [SUM_W-1:0]     out_sum_of_squares;
  wire  [TOTAL_W-1:0]   out_events_in_image;
  wire  [TOTAL_W-1:0]   out_events_dropped;
  wire  [DATA_W-1:0]    prdata;
  wire                  pready;

  rotational_event_warp_contrast_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_action           (in_action),
    .in_event_x          (in_event_x),
    .in_event_y          (in_event_y),
    .empty               (empty),
    .pop                 (pop),
    .out_sum_of_squares  (out_sum_of_squares),
    .out_events_in_image (out_events_in_image),
    .out_events_dropped  (out_events_dropped),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  logic signed [ANGLE_W-1:0] rot_cos = COS_RESET;
  logic signed [ANGLE_W-1:0] rot_sin = SIN_RESET;
  logic [COORD_W-1:0]        rot_cx = CX_RESET;
  logic [COORD_W-1:0]        rot_cy = CY_RESET;

  longint unsigned pix_count [int];
  bit              pix_epoch [int];
  bit              epoch_now = 1'b0;
  longint unsigned sq_acc = 0;
  longint unsigned in_acc = 0;
  longint unsigned out_acc = 0;

  warp_req_t       event_stream [$];
  frame_report_t   frame_reports [$];
  int              n_queued = 0;
  int              n_accepted = 0;
  int              n_reports = 0;
  int              n_errors = 0;
  int              n_settings = 0;
  int              send_gap = 0;
  int              recv_gap = 0;
  int              hold_left = 0;
  bit              long_hold_go = 1'b0;
  bit              no_idle = 1'b0;
  logic [COORD_W-1:0] pool_x [8];
  logic [COORD_W-1:0] pool_y [8];

  function automatic void fold_event(logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
    longint c, s, cx, cy, dx, dy, sx, sy, wx, wy;
    int idx;
    longint unsigned cnt;
    c = rot_cos;
    s = rot_sin;
    cx = longint'(rot_cx);
    cy = longint'(rot_cy);
    dx = longint'(ex) - cx;
    dy = longint'(ey) - cy;
    sx = dx * c - dy * s + cx * Q_ONE;
    sy = dx * s + dy * c + cy * Q_ONE;
    wx = sx / Q_ONE;
    wy = sy / Q_ONE;
    if (wx < 0 || wx >= IMG_W || wy < 0 || wy >= IMG_H) begin
      if (out_acc < TOT_MAX) out_acc++;
      return;
    end
    if (in_acc < TOT_MAX) in_acc++;
    idx = int'(wy) * IMG_W + int'(wx);
    cnt = 0;
    if (pix_epoch.exists(idx) && pix_epoch[idx] == epoch_now) cnt = pix_count[idx];
    pix_epoch[idx] = epoch_now;
    if (cnt < PIX_MAX) begin
      if (sq_acc > SQ_MAX - (2 * cnt + 1)) sq_acc = SQ_MAX;
      else sq_acc += 2 * cnt + 1;
      cnt++;
    end
    pix_count[idx] = cnt;
  endfunction

  function automatic void close_frame();
    frame_report_t rep;
    rep.sum = sq_acc[SUM_W-1:0];
    rep.in_image = in_acc[TOTAL_W-1:0];
    rep.dropped = out_acc[TOTAL_W-1:0];
    frame_reports.insert(frame_reports.size(), rep);
    sq_acc = 0;
    in_acc = 0;
    out_acc = 0;
    epoch_now = ~epoch_now;
  endfunction

  always @(posedge clk) begin
    warp_req_t nxt;
    logic nxt_push;
    nxt_push = push;
    if (push && !full) begin
      if (in_action == ACT_FINISH) close_frame();
      else fold_event(in_event_x, in_event_y);
      n_accepted++;
      nxt_push = 1'b0;
    end
    if (!nxt_push && rst_n) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (event_stream.size() > 0) begin
        nxt = event_stream.pop_front();
        in_action <= nxt.action;
        in_event_x <= nxt.x;
        in_event_y <= nxt.y;
        nxt_push = 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
      end
    end
    push <= nxt_push;
  end

  always @(posedge clk) begin
    frame_report_t want;
    if (pop && !empty) begin
      if (frame_reports.size() == 0) begin
        $display("%0t: report with none pending: sum %0d in %0d dropped %0d", $time,
                 out_sum_of_squares, out_events_in_image, out_events_dropped);
        n_errors++;
      end else begin
        want = frame_reports.pop_front();
        n_reports++;
        if (out_sum_of_squares !== want.sum) begin
          $display("%0t: sum_of_squares expected %0d actual %0d", $time, want.sum,
                   out_sum_of_squares);
          n_errors++;
        end
        if (out_events_in_image !== want.in_image) begin
          $display("%0t: events_in_image expected %0d actual %0d", $time, want.in_image,
                   out_events_in_image);
          n_errors++;
        end
        if (out_events_dropped !== want.dropped) begin
          $display("%0t: events_dropped expected %0d actual %0d", $time, want.dropped,
                   out_events_dropped);
          n_errors++;
        end
      end
    end
    if (long_hold_go) begin
      hold_left = LONG_HOLD;
      long_hold_go = 1'b0;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (!no_idle && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 12);
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] got;
    logic ok;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    case (r)
      REG_COS: rot_cos = value[ANGLE_W-1:0];
      REG_SIN: rot_sin = value[ANGLE_W-1:0];
      REG_CX:  rot_cx = value[COORD_W-1:0];
      REG_CY:  rot_cy = value[COORD_W-1:0];
      default: ;
    endcase
    // read the register back straight after the write
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    got = prdata;
    case (r)
      REG_COS: ok = (got[ANGLE_W-1:0] === rot_cos);
      REG_SIN: ok = (got[ANGLE_W-1:0] === rot_sin);
      REG_CX:  ok = (got[COORD_W-1:0] === rot_cx);
      default: ok = (got[COORD_W-1:0] === rot_cy);
    endcase
    if (!ok) begin
      $display("%0t: register %s read expected %h actual %h", $time, r.name(),
               value & ((r == REG_COS || r == REG_SIN) ? 32'hFFFF : 32'h7FF), got);
      n_errors++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_rotation(logic [ANGLE_W-1:0] c, logic [ANGLE_W-1:0] s,
                              logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    int px, py;
    write_reg(REG_COS, {16'($urandom), c});
    write_reg(REG_SIN, {16'($urandom), s});
    write_reg(REG_CX, {21'($urandom), cx});
    write_reg(REG_CY, {21'($urandom), cy});
    n_settings++;
    for (int i = 0; i < 8; i++) begin
      px = int'(cx) + int'($urandom_range(0, 400)) - 200;
      py = int'(cy) + int'($urandom_range(0, 400)) - 200;
      pool_x[i] = (px < 0) ? '0 : (px > 2047) ? '1 : px[COORD_W-1:0];
      pool_y[i] = (py < 0) ? '0 : (py > 2047) ? '1 : py[COORD_W-1:0];
    end
  endtask

  task automatic queue_item(bit action, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    warp_req_t req;
    req.action = action;
    req.x = x;
    req.y = y;
    event_stream.insert(event_stream.size(), req);
    n_queued++;
  endtask

  task automatic queue_frame(int len);
    int pick, k;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, 7);
      if (pick < 7)
        queue_item(ACT_EVENT, pool_x[k], pool_y[k]);
      else if (pick < 9)
        queue_item(ACT_EVENT, 11'($urandom_range(0, IMG_W - 1)),
                   11'($urandom_range(0, IMG_H - 1)));
      else
        queue_item(ACT_EVENT, 11'($urandom), 11'($urandom));
    end
    queue_item(ACT_FINISH, 11'($urandom), 11'($urandom));
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || frame_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int kind;
    real ang;
    logic [ANGLE_W-1:0] c, s;
    logic [COORD_W-1:0] cx, cy;
    bit pressure_done;
    pressure_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting is the identity about (600, 411): pixels map straight through
    queue_item(ACT_EVENT, 11'd0, 11'd0);
    queue_item(ACT_EVENT, 11'd1279, 11'd719);
    queue_item(ACT_EVENT, 11'd1280, 11'd0);
    queue_item(ACT_EVENT, 11'd0, 11'd720);
    queue_item(ACT_EVENT, 11'd2047, 11'd2047);
    queue_item(ACT_EVENT, 11'd1279, 11'd719);
    repeat (3) queue_item(ACT_EVENT, 11'd5, 11'd5);
    queue_item(ACT_FINISH, 11'd0, 11'd0);
    queue_item(ACT_FINISH, 11'd2047, 11'd2047);
    queue_item(ACT_EVENT, 11'd5, 11'd5);
    queue_item(ACT_FINISH, 11'd1023, 11'd1024);
    wait_drained();

    set_rotation(16'h8000, 16'h7FFF, 11'd0, 11'd0);
    queue_item(ACT_EVENT, 11'd0, 11'd0);
    queue_item(ACT_EVENT, 11'd2047, 11'd2047);
    queue_item(ACT_EVENT, 11'd1, 11'd0);
    queue_item(ACT_EVENT, 11'd0, 11'd1);
    queue_item(ACT_FINISH, 11'd0, 11'd0);
    wait_drained();

    // 45 degrees about the origin: small negative sums truncate to zero
    set_rotation(16'd11585, 16'd11585, 11'd0, 11'd0);
    queue_item(ACT_EVENT, 11'd3, 11'd1);
    queue_item(ACT_EVENT, 11'd1, 11'd3);
    queue_item(ACT_EVENT, 11'd1, 11'd2);
    queue_item(ACT_FINISH, 11'd0, 11'd0);
    wait_drained();

    while (n_queued < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        c = 16'h4000;
        s = 16'h0000;
      end else if (kind == 1) begin
        c = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        s = $urandom_range(0, 1) ? 16'hC000 : 16'h4000;
      end else if (kind == 2) begin
        c = 16'($urandom);
        s = 16'($urandom);
      end else begin
        ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
        c = 16'($rtoi($cos(ang) * 16384.0));
        s = 16'($rtoi($sin(ang) * 16384.0));
      end
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        cx = 11'($urandom_range(0, IMG_W - 1));
        cy = 11'($urandom_range(0, IMG_H - 1));
      end else if (kind == 8) begin
        cx = $urandom_range(0, 1) ? 11'd2047 : 11'd0;
        cy = $urandom_range(0, 1) ? 11'd2047 : 11'd0;
      end else begin
        cx = 11'($urandom);
        cy = 11'($urandom);
      end
      set_rotation(c, s, cx, cy);
      if (!pressure_done && n_queued > RANDOM_ITEMS / 2) begin
        // hold the receiver off while a run of short frames backs the block up
        long_hold_go = 1'b1;
        repeat (16) queue_frame(1);
        pressure_done = 1'b1;
        wait_drained();
      end
      if (n_queued > RANDOM_ITEMS - CALM_TAIL) no_idle = 1'b1;
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) queue_frame(0);
        else queue_frame($urandom_range(1, 40));
      end
      wait_drained();
    end

    wait_drained();
    $display("%0d requests accepted over %0d rotation settings, %0d frame reports checked",
             n_accepted, n_settings, n_reports);
    $display("%0d field mismatches found", n_errors);
    if (n_errors == 0) begin
      $display("rotational_event_warp_contrast_core: match");
    end else begin
      $display("rotational_event_warp_contrast_core: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("rotational_event_warp_contrast_core: mismatch");
    $finish;
  end

endmodule

### rotational_event_warp_contrast_core.f
rtl/rewc_pkg.sv
rtl/rewc_front.sv
rtl/rewc_queue.sv
rtl/rewc_back.sv
rtl/rotational_event_warp_contrast_core.sv
rtl/rewc_checker.sv
dv/rotational_event_warp_contrast_core_tb.sv
